FILE: hw/rtl/brsf_pkg.sv
// brsf_pkg: shared types and constants of the bounded range set filter
// request codes, sequencer states and stream field widths
// no dependencies
package brsf_pkg;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_ADD = 2'd0,
        REQ_FIN = 2'd1,
        REQ_QRY = 2'd2,
        REQ_RST = 2'd3
    } t_req;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_GRD,
        S_GDAT,
        S_SORT,
        S_SRD,
        S_SDAT,
        S_SEND,
        S_MRD,
        S_MDAT,
        S_MEND,
        S_FCHK,
        S_FRD,
        S_FDAT,
        S_FWR,
        S_HRD,
        S_HDAT,
        S_W1RD,
        S_W1DAT,
        S_W1HI,
        S_W2RD,
        S_W2DAT,
        S_APP,
        S_QRD,
        S_QDAT,
        S_DONE
    } t_state;

    // stream widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int CAP_W      = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

endpackage

FILE: hw/rtl/bounded_range_set_filter_unit.sv
// bounded_range_set_filter_unit: top level of the bounded range set filter
// holds the word store, the compaction scratch memory and the sequencer
// depends on brsf_pkg
//
// Usage:
// - input stream: tuser carries the request kind (add, finalize, query,
//   reset set), tdata the key. One request is taken at a time; tready is
//   high only while the sequencer is idle.
// - output stream: one result transaction per request with hit, accepted,
//   words held and ranges held. A finished result waits in the output
//   register; the next request is taken while it waits.
// - config port: capacity register at byte address 0, written in the
//   access cycle, readable back; write it only while the block is idle.
// Request handling, step by step:
// - query: a scan over the stored words; reset set, rejected add: no scan;
//   plain add: the key appended; finalize and a compacting add: gather,
//   bubble sort, merge, fuse steps (compacting add only), write back.
// Each memory has a single read port, so each entry of a scan is read in a
// read state and used in a data state.
// Reset: the set is empty, not frozen, capacity 256; memories are not
// cleared. A stalled output holds its result and the sequencer waits in
// its final state until the register is free.
module bounded_range_set_filter_unit #(
    parameter int MAX_VALUES = 256,
    parameter int KEY_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [brsf_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // key_value[31:0]
    input  logic [brsf_pkg::IN_USER_W-1:0]     i_s_axis_tuser,  // req_type[1:0]
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // hit[0], accepted[1], words_used[10:2], ranges_held[18:11], zeros[23:19]
    output logic [brsf_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int RW = $clog2(MAX_VALUES / 2 + 1);
    localparam int K  = KEY_BITS;
    localparam int E  = 2 * KEY_BITS;
    localparam int CAP_W_L = brsf_pkg::CAP_W;

    // entry weight in words: single one, range two
    function automatic logic [CW-1:0] wt(input logic [E-1:0] e);
        return (e[E-1:K] == e[K-1:0]) ? CW'(1) : CW'(2);
    endfunction

    // state
    brsf_pkg::t_state r_state, n_state;
    logic [1:0]          r_req, n_req;
    logic [K-1:0]        r_key, n_key;
    logic [CW-1:0]       r_wc, n_wc;
    logic [RW-1:0]       r_rc, n_rc;
    logic                r_frozen, n_frozen;
    logic                r_fuse, n_fuse;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_m, n_m;
    logic [CW-1:0]       r_ws, n_ws;
    logic [CW-1:0]       r_best, n_best;
    logic [E-1:0]        r_cur, n_cur;
    logic [E-1:0]        r_bp, n_bp;
    logic [E-1:0]        r_bc, n_bc;
    logic [K-1:0]        r_bd, n_bd;
    logic                r_hit, n_hit;
    logic                r_acc, n_acc;
    logic [CAP_W_L-1:0]  r_cap;
    logic                r_ovalid;
    logic [brsf_pkg::OUT_DATA_W-1:0] r_odata;

    // memory ports
    logic          s_re, s_we, x_re, x_we;
    logic [AW-1:0] s_ra, s_wa, x_ra, x_wa;
    logic [K-1:0]  s_wd, r_s_rd;
    logic [E-1:0]  x_wd, r_x_rd;
    logic [K-1:0]  mem_s [MAX_VALUES];
    logic [E-1:0]  mem_x [MAX_VALUES];

    logic          load_out;
    logic [CW-1:0] eff_cap, two_rc, nxt_i, gn;
    logic [K-1:0]  span;
    logic [E-1:0]  fused;

    // word store
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem_s[s_wa] <= s_wd;
        end
        if (s_re) begin
            r_s_rd <= mem_s[s_ra];
        end
    end

    // scratch entries, start in the upper half so lexicographic order is numeric
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            mem_x[x_wa] <= x_wd;
        end
        if (x_re) begin
            r_x_rd <= mem_x[x_ra];
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= brsf_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_cap <= pwdata[CAP_W_L-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_cap);

    // capacity clamped between 4 and the store size
    always_comb begin
        if (r_cap < 9'd4) begin
            eff_cap = CW'(4);
        end else if (r_cap > MAX_VALUES) begin
            eff_cap = CW'(MAX_VALUES);
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    assign two_rc = CW'(r_rc) << 1;
    assign nxt_i  = r_i + CW'(1);
    assign span   = r_x_rd[K-1:0] - r_cur[E-1:K];
    assign fused  = {r_bp[E-1:K], r_bc[K-1:0]};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_key    = r_key;
        n_wc     = r_wc;
        n_rc     = r_rc;
        n_frozen = r_frozen;
        n_fuse   = r_fuse;
        n_i      = r_i;
        n_n      = r_n;
        n_k      = r_k;
        n_m      = r_m;
        n_ws     = r_ws;
        n_best   = r_best;
        n_cur    = r_cur;
        n_bp     = r_bp;
        n_bc     = r_bc;
        n_bd     = r_bd;
        n_hit    = r_hit;
        n_acc    = r_acc;
        load_out = 1'b0;
        gn       = r_n;
        s_re = 1'b0; s_ra = r_i[AW-1:0];
        s_we = 1'b0; s_wa = r_wc[AW-1:0]; s_wd = r_key;
        x_re = 1'b0; x_ra = r_i[AW-1:0];
        x_we = 1'b0; x_wa = r_i[AW-1:0]; x_wd = r_cur;
        case (r_state)
            brsf_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_req = i_s_axis_tuser;
                    n_key = K'(i_s_axis_tdata);
                    n_hit = 1'b0;
                    n_acc = 1'b1;
                    n_i   = '0;
                    n_n   = '0;
                    n_state = brsf_pkg::S_DONE;
                    case (brsf_pkg::t_req'(i_s_axis_tuser))
                        brsf_pkg::REQ_ADD: begin
                            if (r_frozen) begin
                                n_acc = 1'b0;
                            end else if (({1'b0, r_wc} + 1'b1) > {1'b0, eff_cap}) begin
                                n_fuse  = 1'b1;
                                n_state = brsf_pkg::S_GRD;
                            end else begin
                                n_state = brsf_pkg::S_APP;
                            end
                        end
                        brsf_pkg::REQ_FIN: begin
                            if (!r_frozen) begin
                                if (r_wc != '0) begin
                                    n_fuse  = 1'b0;
                                    n_state = brsf_pkg::S_GRD;
                                end else begin
                                    n_frozen = 1'b1;
                                end
                            end
                        end
                        brsf_pkg::REQ_QRY: begin
                            if (r_wc != '0) begin
                                n_state = brsf_pkg::S_QRD;
                            end
                        end
                        default: begin
                            n_wc     = '0;
                            n_rc     = '0;
                            n_frozen = 1'b0;
                        end
                    endcase
                end
            end
            // gather store words into scratch entries
            brsf_pkg::S_GRD: begin
                s_re    = 1'b1;
                n_state = brsf_pkg::S_GDAT;
            end
            brsf_pkg::S_GDAT: begin
                if (r_i < two_rc) begin
                    if (!r_i[0]) begin
                        n_cur = {r_s_rd, r_cur[K-1:0]};
                    end else begin
                        x_we = 1'b1;
                        x_wa = r_n[AW-1:0];
                        x_wd = {r_cur[E-1:K], r_s_rd};
                        gn   = r_n + CW'(1);
                    end
                end else begin
                    x_we = 1'b1;
                    x_wa = r_n[AW-1:0];
                    x_wd = {r_s_rd, r_s_rd};
                    gn   = r_n + CW'(1);
                end
                n_n = gn;
                n_i = nxt_i;
                if (nxt_i >= r_wc) begin
                    n_m     = gn;
                    n_state = brsf_pkg::S_SORT;
                end else begin
                    n_state = brsf_pkg::S_GRD;
                end
            end
            // bubble sort passes, the largest entry carried to the end
            brsf_pkg::S_SORT: begin
                n_i = '0;
                if (r_m < CW'(2)) begin
                    n_k     = '0;
                    n_ws    = '0;
                    n_state = brsf_pkg::S_MRD;
                end else begin
                    n_state = brsf_pkg::S_SRD;
                end
            end
            brsf_pkg::S_SRD: begin
                x_re    = 1'b1;
                n_state = brsf_pkg::S_SDAT;
            end
            brsf_pkg::S_SDAT: begin
                if (r_i == '0) begin
                    n_cur = r_x_rd;
                end else begin
                    x_we = 1'b1;
                    x_wa = AW'(r_i - CW'(1));
                    if (r_cur > r_x_rd) begin
                        x_wd = r_x_rd;
                    end else begin
                        x_wd  = r_cur;
                        n_cur = r_x_rd;
                    end
                end
                n_i     = nxt_i;
                n_state = (nxt_i == r_m) ? brsf_pkg::S_SEND : brsf_pkg::S_SRD;
            end
            brsf_pkg::S_SEND: begin
                x_we    = 1'b1;
                x_wa    = AW'(r_m - CW'(1));
                x_wd    = r_cur;
                n_m     = r_m - CW'(1);
                n_state = brsf_pkg::S_SORT;
            end
            // merge overlapping or adjacent entries
            brsf_pkg::S_MRD: begin
                x_re    = 1'b1;
                n_state = brsf_pkg::S_MDAT;
            end
            brsf_pkg::S_MDAT: begin
                if (r_i == '0) begin
                    n_cur = r_x_rd;
                end else if (r_x_rd[E-1:K] <= r_cur[K-1:0] ||
                             (r_x_rd[E-1:K] - r_cur[K-1:0]) == K'(1)) begin
                    if (r_x_rd[K-1:0] > r_cur[K-1:0]) begin
                        n_cur = {r_cur[E-1:K], r_x_rd[K-1:0]};
                    end
                end else begin
                    x_we  = 1'b1;
                    x_wa  = r_k[AW-1:0];
                    x_wd  = r_cur;
                    n_ws  = r_ws + wt(r_cur);
                    n_k   = r_k + CW'(1);
                    n_cur = r_x_rd;
                end
                n_i     = nxt_i;
                n_state = (nxt_i == r_n) ? brsf_pkg::S_MEND : brsf_pkg::S_MRD;
            end
            brsf_pkg::S_MEND: begin
                x_we    = 1'b1;
                x_wa    = r_k[AW-1:0];
                x_wd    = r_cur;
                n_ws    = r_ws + wt(r_cur);
                n_n     = r_k + CW'(1);
                n_i     = '0;
                n_wc    = '0;
                n_rc    = '0;
                n_state = r_fuse ? brsf_pkg::S_FCHK : brsf_pkg::S_W1RD;
            end
            // fuse the closest neighbors while over half capacity
            brsf_pkg::S_FCHK: begin
                n_i = '0;
                if (r_n >= CW'(2) && r_ws > (eff_cap >> 1)) begin
                    n_state = brsf_pkg::S_FRD;
                end else begin
                    n_wc    = '0;
                    n_rc    = '0;
                    n_state = brsf_pkg::S_W1RD;
                end
            end
            brsf_pkg::S_FRD: begin
                x_re    = 1'b1;
                n_state = brsf_pkg::S_FDAT;
            end
            brsf_pkg::S_FDAT: begin
                if (r_i != '0 && (r_i == CW'(1) || span < r_bd)) begin
                    n_bd   = span;
                    n_best = r_i;
                    n_bp   = r_cur;
                    n_bc   = r_x_rd;
                end
                n_cur   = r_x_rd;
                n_i     = nxt_i;
                n_state = (nxt_i == r_n) ? brsf_pkg::S_FWR : brsf_pkg::S_FRD;
            end
            brsf_pkg::S_FWR: begin
                x_we = 1'b1;
                x_wa = AW'(r_best - CW'(1));
                x_wd = fused;
                n_ws = r_ws - wt(r_bp) - wt(r_bc) + wt(fused);
                n_i  = r_best;
                if ((r_best + CW'(1)) < r_n) begin
                    n_state = brsf_pkg::S_HRD;
                end else begin
                    n_n     = r_n - CW'(1);
                    n_state = brsf_pkg::S_FCHK;
                end
            end
            // close the gap left by the fused entry
            brsf_pkg::S_HRD: begin
                x_re    = 1'b1;
                x_ra    = nxt_i[AW-1:0];
                n_state = brsf_pkg::S_HDAT;
            end
            brsf_pkg::S_HDAT: begin
                x_we = 1'b1;
                x_wd = r_x_rd;
                n_i  = nxt_i;
                if ((nxt_i + CW'(1)) < r_n) begin
                    n_state = brsf_pkg::S_HRD;
                end else begin
                    n_n     = r_n - CW'(1);
                    n_state = brsf_pkg::S_FCHK;
                end
            end
            // write back ranges first
            brsf_pkg::S_W1RD: begin
                x_re    = 1'b1;
                n_state = brsf_pkg::S_W1DAT;
            end
            brsf_pkg::S_W1DAT: begin
                if (r_x_rd[E-1:K] != r_x_rd[K-1:0]) begin
                    s_we    = 1'b1;
                    s_wd    = r_x_rd[E-1:K];
                    n_wc    = r_wc + CW'(1);
                    n_state = brsf_pkg::S_W1HI;
                end else if (nxt_i < r_n) begin
                    n_i     = nxt_i;
                    n_state = brsf_pkg::S_W1RD;
                end else begin
                    n_i     = '0;
                    n_state = brsf_pkg::S_W2RD;
                end
            end
            brsf_pkg::S_W1HI: begin
                s_we = 1'b1;
                s_wd = r_x_rd[K-1:0];
                n_wc = r_wc + CW'(1);
                n_rc = r_rc + RW'(1);
                if (nxt_i < r_n) begin
                    n_i     = nxt_i;
                    n_state = brsf_pkg::S_W1RD;
                end else begin
                    n_i     = '0;
                    n_state = brsf_pkg::S_W2RD;
                end
            end
            // then singles
            brsf_pkg::S_W2RD: begin
                x_re    = 1'b1;
                n_state = brsf_pkg::S_W2DAT;
            end
            brsf_pkg::S_W2DAT: begin
                if (r_x_rd[E-1:K] == r_x_rd[K-1:0]) begin
                    s_we = 1'b1;
                    s_wd = r_x_rd[K-1:0];
                    n_wc = r_wc + CW'(1);
                end
                n_i = nxt_i;
                if (nxt_i < r_n) begin
                    n_state = brsf_pkg::S_W2RD;
                end else if (r_fuse) begin
                    n_state = brsf_pkg::S_APP;
                end else begin
                    n_frozen = 1'b1;
                    n_state  = brsf_pkg::S_DONE;
                end
            end
            // append the new key as a single
            brsf_pkg::S_APP: begin
                if (r_wc < CW'(MAX_VALUES)) begin
                    s_we = 1'b1;
                    n_wc = r_wc + CW'(1);
                end
                n_state = brsf_pkg::S_DONE;
            end
            // query scan over all stored words
            brsf_pkg::S_QRD: begin
                s_re    = 1'b1;
                n_state = brsf_pkg::S_QDAT;
            end
            brsf_pkg::S_QDAT: begin
                if (r_i < two_rc) begin
                    if (!r_i[0]) begin
                        n_cur = {r_s_rd, r_cur[K-1:0]};
                    end else if (r_key >= r_cur[E-1:K] && r_key <= r_s_rd) begin
                        n_hit = 1'b1;
                    end
                end else if (r_s_rd == r_key) begin
                    n_hit = 1'b1;
                end
                n_i     = nxt_i;
                n_state = (nxt_i < r_wc) ? brsf_pkg::S_QRD : brsf_pkg::S_DONE;
            end
            brsf_pkg::S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = brsf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brsf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == brsf_pkg::S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= brsf_pkg::S_IDLE;
            r_wc     <= '0;
            r_rc     <= '0;
            r_frozen <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wc     <= n_wc;
            r_rc     <= n_rc;
            r_frozen <= n_frozen;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers and result
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_key  <= n_key;
        r_fuse <= n_fuse;
        r_i    <= n_i;
        r_n    <= n_n;
        r_k    <= n_k;
        r_m    <= n_m;
        r_ws   <= n_ws;
        r_best <= n_best;
        r_cur  <= n_cur;
        r_bp   <= n_bp;
        r_bc   <= n_bc;
        r_bd   <= n_bd;
        r_hit  <= n_hit;
        r_acc  <= n_acc;
        if (load_out) begin
            r_odata <= {5'd0, 8'(r_rc), 9'(r_wc), r_acc,
                        r_hit && (r_req == brsf_pkg::REQ_QRY)};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule
